FILE: src/csma_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csma_pkg
// Shared types and constants for the cross-spectrum magnitude accumulator.
// ---------------------------------------------------------------------------
package csma_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned BINS     = 1024;
  localparam int unsigned AccW     = 48;
  localparam int unsigned SmpW     = 16;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic wr_latest;  // store sample as latest of its channel
    logic mul;        // form complex product for pair index
    logic sq;         // square both parts
    logic sqrt_start; // launch square root
    logic acc_rd;     // read accumulator entry
    logic acc_wr;     // write saturated sum back
    logic mirror;     // use swapped pair address
    logic clr_step;   // clear sweep: write one zero entry
    logic out_strobe; // drive result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic sqrt_done;
    logic diag;
    logic clr_last;
  } stat_t;

endpackage

FILE: src/csma_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csma_isqrt
// Iterative 64-bit integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module csma_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [65:0] trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [63:0] rad_q, rad_d;

  // restoring method: bring down two radicand bits per step
  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      rad_d  = rad_i;
      cnt_d  = 6'd0;
      run_d  = 1'b1;
    end else if (run_q) begin
      trial = {rem_q, rad_q[63:62]} - {32'd0, root_q, 2'b01};
      if (!trial[65]) begin
        rem_d  = trial[63:0];
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = {rem_q[61:0], rad_q[63:62]};
        root_d = {root_q[30:0], 1'b0};
      end
      rad_d = {rad_q[61:0], 2'b00};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

FILE: src/csma_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csma_datapath
// Latest-value store, complex product, squares, root unit and accumulators.
// ---------------------------------------------------------------------------
module csma_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           opcode_i,
  input  logic [9:0]           bin_i,
  input  logic [2:0]           channel_i,
  input  logic [2:0]           second_channel_i,
  input  logic signed [15:0]   re_i,
  input  logic signed [15:0]   im_i,
  input  csma_pkg::ctrl_t      ctrl_i,
  output csma_pkg::stat_t      stat_o,
  output logic                 valid_cmd_o,
  output logic [47:0]          acc_value_o
);
  import csma_pkg::*;

  localparam int unsigned ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned BinW  = $clog2(BINS);
  localparam int unsigned Depth = CHANNELS * CHANNELS * BINS;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [31:0]         latest_mem [CHANNELS];
  logic [AccW-1:0]     acc_mem [Depth];

  logic [BinW-1:0]     bin_q;
  logic [ChW-1:0]      ch_q, ch2_q, pair_q;
  logic signed [15:0]  c_q, d_q;
  logic                inrange_q;
  logic signed [32:0]  p_q, q_q;
  logic [63:0]         sq_q;
  logic [31:0]         root;
  logic                sqrt_done;
  logic [AccW-1:0]     rd_q, out_q;
  logic [AddrW-1:0]    clr_q;
  logic [AddrW-1:0]    addr;
  logic [AccW:0]       sum;
  logic [31:0]         latest;
  logic signed [15:0]  a, b;

  assign latest = latest_mem[pair_q];
  assign a = latest[31:16];
  assign b = latest[15:0];

  // input range checks
  always_comb begin
    valid_cmd_o = ({22'd0, bin_i} < 32'(BINS)) && ({29'd0, channel_i} < 32'(CHANNELS));
    if (opcode_i == OP_READ)
      valid_cmd_o = valid_cmd_o && ({29'd0, second_channel_i} < 32'(CHANNELS));
  end

  always_comb begin
    if (ctrl_i.clr_step)
      addr = clr_q;
    else if (ctrl_i.mirror)
      addr = AddrW'(({ch_q, pair_q} * BINS) + bin_q);
    else
      addr = AddrW'(({pair_q, ch_q} * BINS) + bin_q);
  end

  assign sum = {1'b0, rd_q} + {{(AccW - 31){1'b0}}, root};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pair_q <= '0;
    end else begin
      if (ctrl_i.clr_step) clr_q <= clr_q + AddrW'(1);
      if (ctrl_i.load) pair_q <= '0;
      else if (ctrl_i.acc_wr && (ctrl_i.mirror || pair_q == ch_q)) pair_q <= pair_q + ChW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      bin_q     <= BinW'(bin_i);
      ch_q      <= ChW'(channel_i);
      ch2_q     <= ChW'(second_channel_i);
      c_q       <= re_i;
      d_q       <= im_i;
      inrange_q <= valid_cmd_o;
    end
    if (ctrl_i.wr_latest) latest_mem[ch_q] <= {c_q, d_q};
    if (ctrl_i.mul) begin
      p_q <= 33'(a * c_q) - 33'(b * d_q);
      q_q <= 33'(b * c_q) + 33'(a * d_q);
    end
    if (ctrl_i.sq) sq_q <= 64'(p_q * p_q) + 64'(q_q * q_q);
    if (ctrl_i.acc_rd) rd_q <= acc_mem[addr];
    if (ctrl_i.acc_wr)
      acc_mem[addr] <= sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
    if (ctrl_i.clr_step) acc_mem[addr] <= '0;
    if (ctrl_i.out_strobe) out_q <= acc_mem[AddrW'(({ch_q, ch2_q} * BINS) + bin_q)];
  end

  csma_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.sqrt_start),
    .rad_i   (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.diag      = (pair_q == ch_q);
  assign stat_o.clr_last  = (clr_q == AddrW'(Depth - 1));
  assign acc_value_o      = inrange_q ? out_q : '0;
endmodule

FILE: src/csma_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csma_ctrl
// Sequencer: per-pair product, root and one or two read-modify-writes; read; clear sweep.
// ---------------------------------------------------------------------------
module csma_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      opcode_i,
  input  logic            valid_cmd_i,
  input  csma_pkg::stat_t stat_i,
  output csma_pkg::ctrl_t ctrl_o,
  output logic            busy_o,
  output logic            strobe_o
);
  import csma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WLAT, S_MUL, S_SQ, S_LAUNCH, S_ROOT, S_RD0, S_WR0, S_RD1, S_WR1,
    S_READ, S_OUT, S_CLR
  } state_e;

  state_e state_q;
  ctrl_t  c;
  logic   strobe_q;

  // clear sweep runs from reset so the store starts zeroed
  always_comb begin
    c = '0;
    c.load       = (state_q == S_IDLE) && start_i;
    c.wr_latest  = (state_q == S_WLAT);
    c.mul        = (state_q == S_MUL);
    c.sq         = (state_q == S_SQ);
    c.sqrt_start = (state_q == S_LAUNCH);  // radicand is registered by now
    c.acc_rd     = (state_q == S_RD0) || (state_q == S_RD1);
    c.acc_wr     = (state_q == S_WR0) || (state_q == S_WR1);
    c.mirror     = (state_q == S_RD1) || (state_q == S_WR1);
    c.clr_step   = (state_q == S_CLR);
    c.out_strobe = (state_q == S_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          unique case (opcode_i)
            OP_SAMPLE: if (valid_cmd_i) state_q <= S_WLAT;
            OP_READ:   state_q <= S_READ;
            OP_CLEAR:  state_q <= S_CLR;
            default:   state_q <= S_IDLE;
          endcase
        end
        S_WLAT:   state_q <= S_MUL;
        S_MUL:    state_q <= S_SQ;
        S_SQ:     state_q <= S_LAUNCH;
        S_LAUNCH: state_q <= S_ROOT;
        S_ROOT:   if (stat_i.sqrt_done) state_q <= S_RD0;
        S_RD0:    state_q <= S_WR0;
        S_WR0:    state_q <= stat_i.diag ? S_IDLE : S_RD1;
        S_RD1:    state_q <= S_WR1;
        S_WR1:    state_q <= S_MUL;
        S_READ:   state_q <= S_OUT;
        S_OUT: begin
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_CLR:    if (stat_i.clr_last) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign ctrl_o   = c;
  assign busy_o   = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
endmodule

FILE: src/cross_spectrum_magnitude_accumulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cross_spectrum_magnitude_accumulator
// Accumulates cross-spectral magnitudes per channel pair and frequency bin.
// ---------------------------------------------------------------------------
// Usage: drive opcode_i, bin_i, channel_i, second_channel_i, re_i, im_i and
// raise start while busy is low; the word is taken at that edge.
// A sample on channel j runs j+1 pair steps. Each step forms the complex
// product, squares it, launches the bit-serial square root and waits on it,
// then does one or two read-modify-writes on the accumulator memory.
// A read keeps busy high through S_READ, where the result is latched, and
// S_OUT; strobe_o and acc_value_o are then valid as busy falls, and the
// word is taken at the edge that ends the strobe. The receiver cannot
// stall, so the value must be taken then.
// A clear sweeps all CHANNELS*CHANNELS*BINS entries of the memory one
// entry a cycle with busy high. The same sweep runs after reset, so busy
// stays high until it ends, before the first word is taken.
// Samples with out-of-range bin or channel are dropped; out-of-range reads
// return zero.
// ---------------------------------------------------------------------------
module cross_spectrum_magnitude_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [9:0]         bin_i,
  input  logic [2:0]         channel_i,
  input  logic [2:0]         second_channel_i,
  input  logic signed [15:0] re_i,
  input  logic signed [15:0] im_i,
  output logic               strobe_o,
  output logic [47:0]        acc_value_o
);
  import csma_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  valid_cmd;

  csma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .valid_cmd_i (valid_cmd),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .busy_o      (busy),
    .strobe_o    (strobe_o)
  );

  csma_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .opcode_i         (opcode_i),
    .bin_i            (bin_i),
    .channel_i        (channel_i),
    .second_channel_i (second_channel_i),
    .re_i             (re_i),
    .im_i             (im_i),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .valid_cmd_o      (valid_cmd),
    .acc_value_o      (acc_value_o)
  );

  a_one_mem_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.acc_wr && ctrl.clr_step))
    else $error("write and clear together");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result while busy");

  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("strobe longer than one cycle");
endmodule

FILE: tb/sv/tb_cross_spectrum_magnitude_accumulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cross_spectrum_magnitude_accumulator
// Self-checking bench: spectrum words, reads and clears are queued, driven on
// a start/busy handshake and mirrored in a local magnitude-sum predictor;
// each read result is compared against the oldest predicted entry.
// ---------------------------------------------------------------------------
module tb_cross_spectrum_magnitude_accumulator;
  import csma_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    opcode_e           op;
    logic [9:0]        bin;
    logic [2:0]        ch;
    logic [2:0]        ch2;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } spec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start;
  logic busy;
  logic [1:0] opcode_i;
  logic [9:0] bin_i;
  logic [2:0] channel_i, second_channel_i;
  logic signed [15:0] re_i, im_i;
  logic strobe_o;
  logic [47:0] acc_value_o;

  cross_spectrum_magnitude_accumulator dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .bin_i, .channel_i,
    .second_channel_i, .re_i, .im_i, .strobe_o, .acc_value_o
  );

  always #4 clk_i = ~clk_i;

  spec_word_t  pending_words[$];
  spec_word_t  held_word;
  logic [47:0] expected_sums[$];
  logic [47:0] mag_sums[int unsigned];
  logic signed [15:0] chan_re[8], chan_im[8];
  logic [7:0]  chan_written;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic logic [31:0] floor_sqrt(longint unsigned n);
    logic [31:0] r, t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic void bump_sum(int unsigned idx, logic [31:0] m);
    logic [48:0] s;
    s = (mag_sums.exists(idx) ? {1'b0, mag_sums[idx]} : 49'd0) + m;
    mag_sums[idx] = (s > SumMax) ? SumMax : s[47:0];
  endfunction

  // update the local copy for one accepted word
  function automatic void apply_word(spec_word_t w);
    longint p, q;
    longint unsigned sq;
    logic [31:0] m;
    case (w.op)
      OP_SAMPLE: begin
        chan_re[w.ch] = w.re;
        chan_im[w.ch] = w.im;
        for (int i = 0; i <= w.ch; i++) begin
          p = longint'(chan_re[i]) * w.re - longint'(chan_im[i]) * w.im;
          q = longint'(chan_im[i]) * w.re + longint'(chan_re[i]) * w.im;
          sq = longint'(p * p) + longint'(q * q);
          m = floor_sqrt(sq);
          bump_sum({i[2:0], w.ch, w.bin}, m);
          if (i != w.ch) bump_sum({w.ch, i[2:0], w.bin}, m);
        end
      end
      OP_READ: begin
        int unsigned idx;
        idx = {w.ch, w.ch2, w.bin};
        expected_sums.push_back(mag_sums.exists(idx) ? mag_sums[idx] : 48'd0);
      end
      OP_CLEAR: mag_sums.delete();
      default: ;
    endcase
  endfunction

  // driver: start held until taken; gaps of about 12 % outside a quiet stretch
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt;
    logic quiet;
    if (!rst_ni) begin
      start <= 1'b0;
      opcode_i <= OP_NONE;
      bin_i <= '0;
      channel_i <= '0;
      second_channel_i <= '0;
      re_i <= '0;
      im_i <= '0;
    end else begin
      nxt = start;
      quiet = (words_taken > 300 && words_taken < 450);
      if (start && !busy) begin
        apply_word(held_word);
        words_taken++;
        nxt = 1'b0;
      end
      if (!nxt && pending_words.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
        held_word = pending_words.pop_front();
        opcode_i <= held_word.op;
        bin_i <= held_word.bin;
        channel_i <= held_word.ch;
        second_channel_i <= held_word.ch2;
        re_i <= held_word.re;
        im_i <= held_word.im;
        nxt = 1'b1;
      end
      start <= nxt;
    end
  end

  // monitor: results cannot be stalled, one per strobe
  always @(posedge clk_i) begin
    logic [47:0] want;
    if (rst_ni && strobe_o) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", acc_value_o);
      end else begin
        want = expected_sums.pop_front();
        if (acc_value_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("acc_value mismatch: expected %h, got %h", want, acc_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void queue_word(opcode_e op, logic [9:0] bin, logic [2:0] ch,
                                     logic [2:0] ch2, logic [15:0] re, logic [15:0] im);
    spec_word_t w;
    w.op = op; w.bin = bin; w.ch = ch; w.ch2 = ch2; w.re = re; w.im = im;
    if (op == OP_SAMPLE) chan_written[ch] = 1'b1;
    pending_words.push_back(w);
  endfunction

  // a bin's channels 0..top in order, followed by a few reads of that bin
  function automatic void queue_bin_run(logic [9:0] bin, int top);
    for (int c = 0; c <= top; c++)
      queue_word(OP_SAMPLE, bin, c[2:0], 3'($urandom()), pick_value(), pick_value());
    repeat ($urandom_range(3, 1))
      queue_word(OP_READ, bin, 3'($urandom_range(top)), 3'($urandom_range(top)),
                 16'($urandom()), 16'($urandom()));
  endfunction

  initial begin
    int unsigned n;
    int lowest_gap;
    chan_written = '0;
    // directed: extreme values, all channels, extreme bins, clear and idle opcode
    for (int c = 0; c < 8; c++)
      queue_word(OP_SAMPLE, 10'd0, c[2:0], 3'd7, 16'h8000, 16'h8000);
    queue_word(OP_READ, 10'd0, 3'd0, 3'd0, '0, '0);
    queue_word(OP_READ, 10'd0, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF);
    queue_word(OP_READ, 10'd0, 3'd2, 3'd5, '0, '0);
    queue_word(OP_READ, 10'd0, 3'd5, 3'd2, '0, '0);
    queue_word(OP_SAMPLE, 10'd1023, 3'd0, 3'd0, 16'h7FFF, 16'h8000);
    queue_word(OP_SAMPLE, 10'd1023, 3'd1, 3'd0, 16'h7FFF, 16'h7FFF);
    queue_word(OP_READ, 10'd1023, 3'd1, 3'd0, '0, '0);
    queue_word(OP_NONE, 10'd1023, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF);
    queue_word(OP_READ, 10'd512, 3'd3, 3'd4, '0, '0);
    queue_word(OP_CLEAR, 10'd0, 3'd0, 3'd0, '0, '0);
    queue_word(OP_READ, 10'd0, 3'd7, 3'd7, '0, '0);
    queue_word(OP_SAMPLE, 10'd1023, 3'd0, 3'd0, 16'h0001, 16'hFFFF);
    queue_word(OP_READ, 10'd1023, 3'd0, 3'd1, '0, '0);

    n = pending_words.size();
    while (pending_words.size() < n + 700) begin
      case ($urandom_range(19))
        0, 1: queue_word(OP_NONE, 10'($urandom()), 3'($urandom()), 3'($urandom()),
                         16'($urandom()), 16'($urandom()));
        2, 3: queue_word(OP_READ, 10'($urandom()), 3'($urandom()), 3'($urandom()),
                         16'($urandom()), 16'($urandom()));
        4: begin
          // out-of-order channel, only where every lower channel has a value
          lowest_gap = 8;
          for (int c = 7; c >= 0; c--) if (!chan_written[c]) lowest_gap = c;
          queue_word(OP_SAMPLE, 10'($urandom_range(15)), 3'($urandom_range(lowest_gap - 1)),
                     3'($urandom()), pick_value(), pick_value());
        end
        5: if ($urandom_range(9) == 0) queue_word(OP_CLEAR, 10'($urandom()), 3'($urandom()),
                                                   3'($urandom()), 16'($urandom()),
                                                   16'($urandom()));
        default:
          queue_bin_run(($urandom_range(4) == 0) ? 10'($urandom()) : 10'($urandom_range(15)),
                        ($urandom_range(3) == 0) ? 7 : $urandom_range(3));
      endcase
    end

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_words.size() > 0 || start || expected_sums.size() > 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
